// File: design/tsc_pkg.sv
// Shared types, constants and helpers for the three-point slope trend classifier.
// No dependencies; every other file but tsc_if and tsc_tb_pkg imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

  // Trend codes as seen on the result channel
  typedef enum logic [2:0] {
    TREND_STABLE          = 3'd0,
    TREND_RISING          = 3'd1,
    TREND_RISING_QUICKLY  = 3'd2,
    TREND_FALLING         = 3'd3,
    TREND_FALLING_QUICKLY = 3'd4,
    TREND_UNKNOWN         = 3'd5
  } tsc_trend_e;

  // Configuration register indexes, also the order in which thresholds are tried
  typedef enum logic [1:0] {
    REG_RISE_FAST = 2'd0,
    REG_RISE      = 2'd1,
    REG_FALL_FAST = 2'd2,
    REG_FALL      = 2'd3
  } tsc_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_NUM0,
    ST_NUM1,
    ST_NUM2,
    ST_DEN0,
    ST_DEN1,
    ST_DEN2,
    ST_CHK,
    ST_CMP_LO,
    ST_CMP_HI,
    ST_DECIDE,
    ST_DONE
  } tsc_state_e;

  localparam logic [11:0]        EMPTY_VALUE    = 12'd550;
  localparam logic signed [32:0] OFFSET_MAX     = 33'sd1048576;
  localparam logic signed [32:0] OFFSET_MIN     = -33'sd1048576;

  localparam logic [15:0]        RISE_FAST_RST  = 16'd1280;
  localparam logic [15:0]        RISE_RST       = 16'd512;
  localparam logic signed [16:0] FALL_FAST_RST  = -17'sd1280;
  localparam logic signed [16:0] FALL_RST       = -17'sd512;

  // Q8 thresholds in value units per second
  typedef struct packed {
    logic [15:0]        rise_fast;
    logic [15:0]        rise;
    logic signed [16:0] fall_fast;
    logic signed [16:0] fall;
  } tsc_thr_t;

  // One command to the shared multiply-accumulate unit
  typedef struct packed {
    logic               en;
    logic               use_base;
    logic               sub;
    logic               shift_hi;
    logic signed [63:0] base;
    logic signed [23:0] a;
    logic signed [23:0] b;
  } tsc_mac_op_t;

  // Signed time difference, saturated to +/- 2^20 s
  function automatic logic signed [21:0] time_offset(input logic [31:0] t,
                                                     input logic [31:0] base);
    logic signed [32:0] d;
    logic signed [21:0] r;
    d = signed'({1'b0, t}) - signed'({1'b0, base});
    if (d > OFFSET_MAX) begin
      r = signed'(OFFSET_MAX[21:0]);
    end else if (d < OFFSET_MIN) begin
      r = signed'(OFFSET_MIN[21:0]);
    end else begin
      r = signed'(d[21:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/tsc_if.sv
// Valid/ready channel interfaces of the classifier: reading input, result output
// and configuration write port. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tsc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] reading_time;
  logic [11:0] reading_value;

  modport source (output valid, mode, reading_time, reading_value, input ready);
  modport sink   (input valid, mode, reading_time, reading_value, output ready);
endinterface

interface tsc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  trend_code;
  logic [11:0] latest_value;

  modport source (output valid, trend_code, latest_value, input ready);
  modport sink   (input valid, trend_code, latest_value, output ready);
endinterface

interface tsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/tsc_cfg_regs.sv
// Threshold configuration registers of the classifier.
// Depends on tsc_pkg and tsc_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module tsc_cfg_regs
  import tsc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tsc_cfg_if.sink    cfg_i,
  output tsc_thr_t   thr_o
);

  tsc_thr_t thr_q;

  assign cfg_i.ready = 1'b1;
  assign thr_o       = thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.rise_fast <= RISE_FAST_RST;
      thr_q.rise      <= RISE_RST;
      thr_q.fall_fast <= FALL_FAST_RST;
      thr_q.fall      <= FALL_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (tsc_reg_e'(cfg_i.index))
        REG_RISE_FAST: thr_q.rise_fast <= cfg_i.data[15:0];
        REG_RISE:      thr_q.rise      <= cfg_i.data[15:0];
        REG_FALL_FAST: thr_q.fall_fast <= signed'(cfg_i.data);
        REG_FALL:      thr_q.fall      <= signed'(cfg_i.data);
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/tsc_mac.sv
// Shared 24x24 signed multiply-accumulate unit with a 64-bit accumulator.
// Depends on tsc_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module tsc_mac
  import tsc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire tsc_mac_op_t  op_i,
  output logic signed [63:0] acc_o
);

  logic signed [47:0] prod;
  logic signed [63:0] addend;
  logic signed [63:0] start;
  logic signed [63:0] acc_d;
  logic signed [63:0] acc_q;

  always_comb begin
    prod   = op_i.a * op_i.b;
    addend = {{16{prod[47]}}, prod};
    // upper half of a split operand lands 22 bits up
    if (op_i.shift_hi) begin
      addend = addend <<< 22;
    end
    start = op_i.use_base ? op_i.base : acc_q;
    acc_d = op_i.sub ? (start - addend) : (start + addend);
    if (!op_i.en) begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// File: design/tsc_seq.sv
// Sequencer of the classifier: reading history, handshakes, result register and
// the micro-sequence that drives the shared MAC. Depends on tsc_pkg and tsc_if.
`timescale 1ns / 1ps
`default_nettype none

module tsc_seq
  import tsc_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tsc_in_if.sink             in_i,
  tsc_out_if.source          out_o,
  input  wire tsc_thr_t      thr_i,
  input  wire logic signed [63:0] acc_i,
  output tsc_mac_op_t        op_o
);

  tsc_state_e         state_q, state_d;
  logic [31:0]        times_q [3];
  logic [31:0]        times_d [3];
  logic [11:0]        values_q [3];
  logic [11:0]        values_d [3];
  logic [1:0]         count_q, count_d;
  tsc_trend_e         trend_q, trend_d;
  logic signed [21:0] x1_q, x1_d, x2_q, x2_d;
  logic signed [22:0] sx_q, sx_d;
  logic [13:0]        sy_q, sy_d;
  logic signed [36:0] num_q, num_d;
  logic [43:0]        den_q, den_d;
  tsc_reg_e           idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  tsc_trend_e         out_trend_q, out_trend_d;
  logic [11:0]        out_latest_q, out_latest_d;

  logic [13:0]        y1x3, y2x3;
  logic signed [23:0] thr_ext;
  tsc_trend_e         hit_code;
  logic               hit;

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.trend_code   = out_trend_q;
  assign out_o.latest_value = out_latest_q;

  // threshold under test and the trend it stands for
  always_comb begin
    unique case (idx_q)
      REG_RISE_FAST: begin
        thr_ext  = signed'({8'b0, thr_i.rise_fast});
        hit_code = TREND_RISING_QUICKLY;
      end
      REG_RISE: begin
        thr_ext  = signed'({8'b0, thr_i.rise});
        hit_code = TREND_RISING;
      end
      REG_FALL_FAST: begin
        thr_ext  = {{7{thr_i.fall_fast[16]}}, thr_i.fall_fast};
        hit_code = TREND_FALLING_QUICKLY;
      end
      REG_FALL: begin
        thr_ext  = {{7{thr_i.fall[16]}}, thr_i.fall};
        hit_code = TREND_FALLING;
      end
    endcase
  end

  // acc holds 256*num - thr*den; rising tests want it positive, falling negative
  assign hit = (idx_q == REG_RISE_FAST || idx_q == REG_RISE) ?
               (!acc_i[63] && (acc_i != 64'sd0)) : acc_i[63];

  assign y1x3 = {1'b0, values_q[1], 1'b0} + {2'b0, values_q[1]};
  assign y2x3 = {1'b0, values_q[2], 1'b0} + {2'b0, values_q[2]};

  always_comb begin
    state_d      = state_q;
    times_d      = times_q;
    values_d     = values_q;
    count_d      = count_q;
    trend_d      = trend_q;
    x1_d         = x1_q;
    x2_d         = x2_q;
    sx_d         = sx_q;
    sy_d         = sy_q;
    num_d        = num_q;
    den_d        = den_q;
    idx_d        = idx_q;
    out_trend_d  = out_trend_q;
    out_latest_d = out_latest_q;
    out_valid_d  = out_valid_q && !out_o.ready;

    op_o          = '0;
    op_o.use_base = 1'b1;
    op_o.base     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.mode) begin
            count_d = 2'd0;
            trend_d = TREND_UNKNOWN;
            state_d = ST_DONE;
          end else begin
            times_d[0]  = times_q[1];
            times_d[1]  = times_q[2];
            times_d[2]  = in_i.reading_time;
            values_d[0] = values_q[1];
            values_d[1] = values_q[2];
            values_d[2] = in_i.reading_value;
            if (count_q >= 2'd2) begin
              count_d = 2'd3;
              state_d = ST_PREP;
            end else begin
              count_d = count_q + 2'd1;
              trend_d = TREND_STABLE;
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_PREP: begin
        // offsets from the oldest reading; its own offset is zero
        x1_d    = time_offset(times_q[1], times_q[0]);
        x2_d    = time_offset(times_q[2], times_q[0]);
        sx_d    = {x1_d[21], x1_d} + {x2_d[21], x2_d};
        sy_d    = {2'b0, values_q[0]} + {2'b0, values_q[1]} + {2'b0, values_q[2]};
        state_d = ST_NUM0;
      end
      // num = x1*3y1 + x2*3y2 - sx*sy
      ST_NUM0: begin
        op_o.en = 1'b1;
        op_o.a  = {{2{x1_q[21]}}, x1_q};
        op_o.b  = signed'({10'b0, y1x3});
        state_d = ST_NUM1;
      end
      ST_NUM1: begin
        op_o.en       = 1'b1;
        op_o.use_base = 1'b0;
        op_o.a        = {{2{x2_q[21]}}, x2_q};
        op_o.b        = signed'({10'b0, y2x3});
        state_d       = ST_NUM2;
      end
      ST_NUM2: begin
        op_o.en       = 1'b1;
        op_o.use_base = 1'b0;
        op_o.sub      = 1'b1;
        op_o.a        = {sx_q[22], sx_q};
        op_o.b        = signed'({10'b0, sy_q});
        state_d       = ST_DEN0;
      end
      // den = 2*(x1*x1 - x1*x2 + x2*x2)
      ST_DEN0: begin
        num_d   = acc_i[36:0];
        op_o.en = 1'b1;
        op_o.a  = {{2{x1_q[21]}}, x1_q};
        op_o.b  = {x1_q[21], x1_q, 1'b0};
        state_d = ST_DEN1;
      end
      ST_DEN1: begin
        op_o.en       = 1'b1;
        op_o.use_base = 1'b0;
        op_o.sub      = 1'b1;
        op_o.a        = {{2{x1_q[21]}}, x1_q};
        op_o.b        = {x2_q[21], x2_q, 1'b0};
        state_d       = ST_DEN2;
      end
      ST_DEN2: begin
        op_o.en       = 1'b1;
        op_o.use_base = 1'b0;
        op_o.a        = {{2{x2_q[21]}}, x2_q};
        op_o.b        = {x2_q[21], x2_q, 1'b0};
        state_d       = ST_CHK;
      end
      ST_CHK: begin
        den_d = acc_i[43:0];
        idx_d = REG_RISE_FAST;
        // equal timestamps leave no slope
        if (acc_i == 64'sd0) begin
          trend_d = TREND_STABLE;
          state_d = ST_DONE;
        end else begin
          state_d = ST_CMP_LO;
        end
      end
      ST_CMP_LO: begin
        op_o.en   = 1'b1;
        op_o.sub  = 1'b1;
        op_o.base = {{19{num_q[36]}}, num_q, 8'b0};
        op_o.a    = thr_ext;
        op_o.b    = signed'({2'b0, den_q[21:0]});
        state_d   = ST_CMP_HI;
      end
      ST_CMP_HI: begin
        op_o.en       = 1'b1;
        op_o.use_base = 1'b0;
        op_o.sub      = 1'b1;
        op_o.shift_hi = 1'b1;
        op_o.a        = thr_ext;
        op_o.b        = signed'({2'b0, den_q[43:22]});
        state_d       = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (hit) begin
          trend_d = hit_code;
          state_d = ST_DONE;
        end else begin
          unique case (idx_q)
            REG_RISE_FAST: begin
              idx_d   = REG_RISE;
              state_d = ST_CMP_LO;
            end
            REG_RISE: begin
              idx_d   = REG_FALL_FAST;
              state_d = ST_CMP_LO;
            end
            REG_FALL_FAST: begin
              idx_d   = REG_FALL;
              state_d = ST_CMP_LO;
            end
            REG_FALL: begin
              trend_d = TREND_STABLE;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_trend_d  = trend_q;
          out_latest_d = (count_q == 2'd0) ? EMPTY_VALUE : values_q[2];
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= 2'd0;
      trend_q     <= TREND_STABLE;
      out_valid_q <= 1'b0;
      idx_q       <= REG_RISE_FAST;
      for (int i = 0; i < 3; i++) begin
        times_q[i]  <= '0;
        values_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      trend_q     <= trend_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      times_q     <= times_d;
      values_q    <= values_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q         <= x1_d;
    x2_q         <= x2_d;
    sx_q         <= sx_d;
    sy_q         <= sy_d;
    num_q        <= num_d;
    den_q        <= den_d;
    out_trend_q  <= out_trend_d;
    out_latest_q <= out_latest_d;
  end

endmodule

`default_nettype wire

// File: design/three_point_slope_trend_classifier_top.sv
// Top level of the three-point slope trend classifier.
// Depends on tsc_pkg, tsc_if, tsc_cfg_regs, tsc_mac and tsc_seq.
`timescale 1ns / 1ps
`default_nettype none

// Takes one word at a time on in_i and returns exactly one result word on out_o
// for each. A clear word, or a reading while fewer than three are held, goes
// straight to the done state, which loads the result register. A full fit runs
// a prep step, six passes through the single 24x24 multiply-accumulate unit to
// build the numerator and denominator of the slope, a check of the
// denominator (all three timestamps equal end the fit there), then each
// threshold tried (one to four, in the order rise fast, rise, fall fast, fall)
// takes a decide step after two passes on the same multiplier, because the
// denominator is split into 22-bit halves, and last the done state loads
// the result register. in_i is not ready while a word is in work and comes back
// in the cycle the result turns valid. A finished result waits in the output
// register while the next word is accepted and worked; that word holds at its
// end until the register is free. Thresholds are written on cfg_i, which is
// always ready, while the block is idle; the user must keep to this, as the
// block itself does not enforce it.

module three_point_slope_trend_classifier_top
  import tsc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tsc_in_if.sink     in_i,
  tsc_out_if.source  out_o,
  tsc_cfg_if.sink    cfg_i
);

  tsc_thr_t           thr;
  tsc_mac_op_t        mac_op;
  logic signed [63:0] mac_acc;

  tsc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .thr_o  (thr)
  );

  tsc_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .acc_o (mac_acc)
  );

  tsc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .thr_i  (thr),
    .acc_i  (mac_acc),
    .op_o   (mac_op)
  );

endmodule

`default_nettype wire

// File: dv/tsc_tb_pkg.sv
// Testbench-side codes for the slope trend classifier environment.
// No dependencies; imported by the checker and the testbench top.
`timescale 1ns / 1ps

package tsc_tb_pkg;

  // Meaning of the mode bit of an input word
  typedef enum logic {
    MODE_ADD   = 1'b0,
    MODE_CLEAR = 1'b1
  } tsc_mode_e;

endpackage

// File: dv/tsc_trend_checker.sv
// Checker for the three-point slope trend classifier: tracks threshold writes,
// predicts each result word and compares it with the output channel.
// Depends on tsc_pkg, tsc_tb_pkg and the tsc_*_if interfaces.
`timescale 1ns / 1ps

module tsc_trend_checker
  import tsc_pkg::*;
  import tsc_tb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tsc_in_if    in_w,
  tsc_out_if   out_w,
  tsc_cfg_if   cfg_w,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    tsc_trend_e  trend;
    logic [11:0] latest;
  } trend_word_t;

  tsc_thr_t    thr;
  logic [31:0] hist_time [3];
  logic [11:0] hist_value [3];
  int          held;
  tsc_trend_e  trend_now;
  trend_word_t pending_trends [$];

  function automatic longint offset_from_oldest(logic [31:0] t, logic [31:0] base);
    longint d;
    d = longint'({32'd0, t}) - longint'({32'd0, base});
    if (d > longint'(OFFSET_MAX)) begin
      d = longint'(OFFSET_MAX);
    end else if (d < longint'(OFFSET_MIN)) begin
      d = longint'(OFFSET_MIN);
    end
    return d;
  endfunction

  // Least-squares fit over the three held readings, compared without division
  function automatic tsc_trend_e fit_slope_trend();
    longint sx, sy, sxy, sx2, x, y, num, den, lhs;
    sx  = 0;
    sy  = 0;
    sxy = 0;
    sx2 = 0;
    for (int i = 0; i < 3; i++) begin
      x   = offset_from_oldest(hist_time[i], hist_time[0]);
      y   = longint'({52'd0, hist_value[i]});
      sx  += x;
      sy  += y;
      sxy += x * y;
      sx2 += x * x;
    end
    num = 3 * sxy - sx * sy;
    den = 3 * sx2 - sx * sx;
    if (den <= 0) begin
      return TREND_STABLE;
    end
    lhs = num * 256;
    if (lhs > longint'({48'd0, thr.rise_fast}) * den) begin
      return TREND_RISING_QUICKLY;
    end
    if (lhs > longint'({48'd0, thr.rise}) * den) begin
      return TREND_RISING;
    end
    if (lhs < longint'({{47{thr.fall_fast[16]}}, thr.fall_fast}) * den) begin
      return TREND_FALLING_QUICKLY;
    end
    if (lhs < longint'({{47{thr.fall[16]}}, thr.fall}) * den) begin
      return TREND_FALLING;
    end
    return TREND_STABLE;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    trend_word_t want;
    if (!rst_ni) begin
      thr.rise_fast = RISE_FAST_RST;
      thr.rise      = RISE_RST;
      thr.fall_fast = FALL_FAST_RST;
      thr.fall      = FALL_RST;
      for (int i = 0; i < 3; i++) begin
        hist_time[i]  = '0;
        hist_value[i] = '0;
      end
      held         = 0;
      trend_now    = TREND_STABLE;
      pending_trends.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        case (tsc_reg_e'(cfg_w.index))
          REG_RISE_FAST: thr.rise_fast = cfg_w.data[15:0];
          REG_RISE:      thr.rise      = cfg_w.data[15:0];
          REG_FALL_FAST: thr.fall_fast = cfg_w.data;
          REG_FALL:      thr.fall      = cfg_w.data;
          default: ;
        endcase
      end

      if (out_w.valid && out_w.ready) begin
        if (pending_trends.size() == 0) begin
          $error("unexpected result word: trend_code=%0d latest_value=%0d",
                 out_w.trend_code, out_w.latest_value);
          fail_count_o++;
        end else begin
          want = pending_trends.pop_front();
          if (out_w.trend_code !== want.trend) begin
            $error("trend_code mismatch: expected %0d, actual %0d",
                   want.trend, out_w.trend_code);
            fail_count_o++;
          end
          if (out_w.latest_value !== want.latest) begin
            $error("latest_value mismatch: expected %0d, actual %0d",
                   want.latest, out_w.latest_value);
            fail_count_o++;
          end
        end
      end

      if (in_w.valid && in_w.ready) begin
        if (tsc_mode_e'(in_w.mode) == MODE_CLEAR) begin
          // stored readings stay, they just stop counting
          held      = 0;
          trend_now = TREND_UNKNOWN;
        end else begin
          hist_time[0]  = hist_time[1];
          hist_time[1]  = hist_time[2];
          hist_time[2]  = in_w.reading_time;
          hist_value[0] = hist_value[1];
          hist_value[1] = hist_value[2];
          hist_value[2] = in_w.reading_value;
          if (held < 3) begin
            held++;
          end
          trend_now = (held < 3) ? TREND_STABLE : fit_slope_trend();
        end
        want.trend  = trend_now;
        want.latest = (held == 0) ? EMPTY_VALUE : hist_value[2];
        pending_trends.push_back(want);
      end

      pending_o = pending_trends.size();
    end
  end

endmodule

// File: dv/tb_top.sv
// Testbench top for three_point_slope_trend_classifier_top: drives readings and
// threshold writes, paces the result channel and reports the verdict.
// Depends on tsc_pkg, tsc_tb_pkg, the tsc_*_if interfaces and tsc_trend_checker.
`timescale 1ns / 1ps

module tb_top;
  import tsc_pkg::*;
  import tsc_tb_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int PHASE_WORDS  = 200;
  localparam int TAIL_CYCLES  = 30;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int stall_left;
  int fail_count;
  int pending_count;

  logic [31:0] last_time;
  logic [11:0] last_value;

  tsc_in_if  in_ch();
  tsc_out_if out_ch();
  tsc_cfg_if cfg_ch();

  three_point_slope_trend_classifier_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  tsc_trend_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_w         (in_ch),
    .out_w        (out_ch),
    .cfg_w        (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Result side: after each accepted word, drop ready for a random stall (possibly none) while rx_idle is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (out_ch.valid && out_ch.ready) begin
      stall_left = rx_idle ? $urandom_range(0, 5) : 0;
      out_ch.ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= (stall_left == 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Hold valid between back-to-back words; lower it only for a real gap
  task automatic send_word(tsc_mode_e m, logic [31:0] t, logic [11:0] v);
    int gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= m;
    in_ch.reading_time  <= t;
    in_ch.reading_value <= v;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Stop sending and wait until every predicted word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(tsc_reg_e idx, logic [16:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic set_thresholds(logic [16:0] rf, logic [16:0] r,
                                logic [16:0] ff, logic [16:0] f);
    write_reg(REG_RISE_FAST, rf);
    write_reg(REG_RISE, r);
    write_reg(REG_FALL_FAST, ff);
    write_reg(REG_FALL, f);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly plausible sensor streams, plus clears, jumps and raw noise
  task automatic run_readings(int n);
    int          pick;
    int          nv;
    logic [31:0] t;
    logic [11:0] v;
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) == 0) begin
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_word(MODE_CLEAR, $urandom, 12'($urandom_range(0, 4095)));
      end else begin
        if (pick < 10) begin
          t = $urandom;
          v = 12'($urandom_range(0, 4095));
        end else if (pick < 16) begin
          if ($urandom_range(0, 1) == 1) begin
            t = last_time + 32'($urandom_range(0, 3000000));
          end else begin
            t = last_time - 32'($urandom_range(0, 3000000));
          end
          v = 12'($urandom_range(0, 4095));
        end else begin
          t  = (pick < 20) ? last_time : last_time + 32'($urandom_range(1, 20));
          nv = int'(last_value) + int'($urandom_range(0, 240)) - 120;
          if (nv < 0) begin
            nv = 0;
          end else if (nv > 4095) begin
            nv = 4095;
          end
          v = 12'(nv);
        end
        last_time  = t;
        last_value = v;
        send_word(MODE_ADD, t, v);
      end
    end
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= MODE_ADD;
    in_ch.reading_time  <= '0;
    in_ch.reading_value <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_RISE_FAST;
    cfg_ch.data         <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset thresholds
    send_word(MODE_CLEAR, 32'hFFFF_FFFF, 12'd4095);
    send_word(MODE_ADD, 32'd1000, 12'd0);
    send_word(MODE_ADD, 32'd1010, 12'd100);
    send_word(MODE_ADD, 32'd1020, 12'd200);
    send_word(MODE_ADD, 32'd1030, 12'd200);   // slope right at the rise fast limit
    send_word(MODE_ADD, 32'd1040, 12'd200);
    send_word(MODE_ADD, 32'd1050, 12'd100);   // slope right at the fall fast limit
    send_word(MODE_ADD, 32'd1060, 12'd0);
    send_word(MODE_ADD, 32'd1060, 12'd4095);
    send_word(MODE_ADD, 32'd1060, 12'd0);     // all three timestamps equal
    send_word(MODE_ADD, 32'hFFFF_FFFF, 12'd0);
    send_word(MODE_ADD, 32'd0, 12'd4095);
    send_word(MODE_ADD, 32'h8000_0000, 12'd2048);
    send_word(MODE_ADD, 32'h0020_0000, 12'd4095);
    send_word(MODE_ADD, 32'h0010_0000, 12'd1);
    send_word(MODE_CLEAR, 32'd0, 12'd0);
    send_word(MODE_CLEAR, 32'h5555_AAAA, 12'hAAA);
    send_word(MODE_ADD, 32'd5, 12'd10);
    send_word(MODE_ADD, 32'd6, 12'd4095);
    send_word(MODE_ADD, 32'd7, 12'd0);
    last_time  = 32'd7;
    last_value = 12'd0;
    run_readings(PHASE_WORDS);

    drain();
    set_thresholds(17'h0FFFF, 17'h0FFFF, 17'h10000, 17'h10000);
    run_readings(PHASE_WORDS);

    drain();
    set_thresholds(17'd0, 17'd0, 17'd0, 17'd0);
    run_readings(PHASE_WORDS);

    drain();
    set_thresholds({1'b1, 16'($urandom_range(512, 3000))},
                   {1'b1, 16'($urandom_range(0, 1500))},
                   17'(-int'($urandom_range(512, 3000))),
                   17'(-int'($urandom_range(0, 1500))));
    run_readings(PHASE_WORDS);

    // Overlapping limits, falling thresholds above zero
    drain();
    set_thresholds(17'd100, 17'd2000, 17'd300, 17'd1000);
    run_readings(PHASE_WORDS);

    drain();
    set_thresholds(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
    run_readings(PHASE_WORDS);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[three_point_slope_trend_classifier_top] OK");
    end else begin
      $display("[three_point_slope_trend_classifier_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[three_point_slope_trend_classifier_top] ERROR");
    $finish;
  end

endmodule

// File: sim.f
design/tsc_pkg.sv
design/tsc_if.sv
design/tsc_cfg_regs.sv
design/tsc_mac.sv
design/tsc_seq.sv
design/three_point_slope_trend_classifier_top.sv
dv/tsc_tb_pkg.sv
dv/tsc_trend_checker.sv
dv/tb_top.sv
